// ===== src/esfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfm_pkg
// Shared constants and types of the extremum spacing frequency meter.
// ----------------------------------------------------------------------------
package esfm_pkg;

  localparam int unsigned MAX_BLOCK_SAMPLES = 1024;
  localparam int unsigned IDX_W    = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W   = 20;
  localparam int unsigned FREQ_W   = 27;
  localparam int unsigned GAP_W    = 10;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned NUM_W    = RATE_W + FRAC_W;
  localparam int unsigned DEN_W    = GAP_W + 1;
  localparam int unsigned CNT_W    = $clog2(NUM_W + 1);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(10000);
  localparam logic [IDX_W-1:0]  IDX_LIMIT  = IDX_W'(MAX_BLOCK_SAMPLES);

  // divider status toward the sequencing logic
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/esfm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfm_if
// Valid/ready channels of the frequency meter: samples, results, rate writes.
// ----------------------------------------------------------------------------
interface esfm_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_value;
  logic        block_last;

  modport source (output valid, sample_value, block_last, input ready);
  modport sink   (input valid, sample_value, block_last, output ready);
endinterface

interface esfm_result_if;
  logic        valid;
  logic        ready;
  logic [26:0] frequency_q8;
  logic [9:0]  half_period_samples;
  logic        no_estimate;

  modport source (output valid, frequency_q8, half_period_samples, no_estimate,
                  input ready);
  modport sink   (input valid, frequency_q8, half_period_samples, no_estimate,
                  output ready);
endinterface

interface esfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] sample_rate_hz;

  modport source (output valid, sample_rate_hz, input ready);
  modport sink   (input valid, sample_rate_hz, output ready);
endinterface

// ===== src/esfm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esfm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esfm_div
  import esfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              take_i,
  output div_stat_t         stat_o,
  output logic [FREQ_W-1:0] quot_o
);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // numerator bits shift out at the top while quotient bits enter at the bottom
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = done_q;
    if (take_i) begin
      done_d = 1'b0;
    end
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CNT_W'(NUM_W);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q[FREQ_W-1:0];

endmodule

// ===== src/extremum_spacing_frequency_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extremum_spacing_frequency_meter
// Finds the first two direction changes of a sample block and reports
// sample_rate / (2 * gap) in Q8 for each block once its last sample is taken, or no estimate.
// ----------------------------------------------------------------------------
// samples that do not close a block are taken one per cycle
// a block's last sample starts the bit-serial divider, one quotient bit per
// numerator bit; the result is registered once the divider is done and the output is free
// sample input stays closed from the last sample until the result is registered
// reset (rst_ni low, asynchronous) clears block state, sets the rate to 10000
module extremum_spacing_frequency_meter
  import esfm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  esfm_sample_if.sink   sample_i,
  esfm_cfg_if.sink      cfg_i,
  esfm_result_if.source result_o
);

  logic [RATE_W-1:0]   rate_q;
  logic [SAMPLE_W-1:0] prev_q, prev_d;
  logic                rising_q, rising_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [GAP_W-1:0]    first_q, first_d;
  logic [GAP_W-1:0]    second_q, second_d;
  logic [1:0]          found_q, found_d;
  logic                job_q;
  logic [GAP_W-1:0]    gap_q;
  logic                no_est_q;
  logic                out_valid_q;
  logic [FREQ_W-1:0]   out_freq_q;
  logic [GAP_W-1:0]    out_gap_q;
  logic                out_no_est_q;

  logic                in_acc;
  logic                blk_end;
  logic [GAP_W-1:0]    pair;
  logic                dir;
  logic [GAP_W-1:0]    gap_d;
  logic                no_est_d;
  logic                load_out;
  div_stat_t           div_stat;
  logic [FREQ_W-1:0]   quot;

  assign sample_i.ready = !job_q;
  assign cfg_i.ready    = 1'b1;
  assign in_acc         = sample_i.valid && sample_i.ready;
  assign blk_end        = in_acc && sample_i.block_last;

  assign pair = GAP_W'(idx_q - IDX_W'(1));
  assign dir  = prev_q < sample_i.sample_value;

  always_comb begin
    prev_d   = prev_q;
    rising_d = rising_q;
    idx_d    = idx_q;
    first_d  = first_q;
    second_d = second_q;
    found_d  = found_q;
    if (in_acc) begin
      if (idx_q != '0 && idx_q < IDX_LIMIT && found_q < 2'd2) begin
        if (pair != '0 && dir != rising_q) begin
          if (found_q == 2'd0) begin
            first_d = pair;
          end else begin
            second_d = pair;
          end
          found_d = found_q + 2'd1;
        end
        rising_d = dir;
      end
      prev_d = sample_i.sample_value;
      if (idx_q < IDX_LIMIT) begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  assign gap_d    = second_d - first_d;
  assign no_est_d = found_d < 2'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RATE_RESET;
      prev_q   <= '0;
      rising_q <= 1'b0;
      idx_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      found_q  <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        rate_q <= cfg_i.sample_rate_hz;
      end
      if (blk_end) begin
        prev_q   <= '0;
        rising_q <= 1'b0;
        idx_q    <= '0;
        first_q  <= '0;
        second_q <= '0;
        found_q  <= '0;
      end else begin
        prev_q   <= prev_d;
        rising_q <= rising_d;
        idx_q    <= idx_d;
        first_q  <= first_d;
        second_q <= second_d;
        found_q  <= found_d;
      end
    end
  end

  // a zero denominator runs through too; its quotient is masked by no_est_q
  esfm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(blk_end),
    .num_i  ({rate_q, FRAC_W'(0)}),
    .den_i  ({gap_d, 1'b0}),
    .take_i (load_out),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  assign load_out = job_q && div_stat.done && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i) begin
    if (blk_end) begin
      gap_q    <= gap_d;
      no_est_q <= no_est_d;
    end
    if (load_out) begin
      out_freq_q   <= no_est_q ? '0 : quot;
      out_gap_q    <= no_est_q ? '0 : gap_q;
      out_no_est_q <= no_est_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (blk_end) begin
        job_q <= 1'b1;
      end else if (load_out) begin
        job_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid               = out_valid_q;
  assign result_o.frequency_q8        = out_freq_q;
  assign result_o.half_period_samples = out_gap_q;
  assign result_o.no_estimate         = out_no_est_q;

  // divider only runs for a pending block result
  a_busy_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> job_q && !sample_i.ready)
    else $error("divider running without a pending block");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_end |=> div_stat.busy && !div_stat.done)
    else $error("last item did not start the divider");

  a_no_est: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.no_estimate |->
      result_o.frequency_q8 == '0 && result_o.half_period_samples == '0)
    else $error("no estimate item carries nonzero fields");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.no_estimate |-> result_o.half_period_samples != '0)
    else $error("estimate with zero gap");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the extremum spacing frequency meter. It drives
// sample blocks and rate writes over valid/ready channels, predicts each
// block's frequency estimate and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
  import esfm_pkg::*;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_q8;
    logic [GAP_W-1:0]  half_period;
    logic              no_estimate;
  } estimate_t;

  logic clk_i;
  logic rst_ni;

  esfm_sample_if sample_if ();
  esfm_cfg_if    cfg_if ();
  esfm_result_if result_if ();

  extremum_spacing_frequency_meter u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  // predicted block state
  logic [RATE_W-1:0]   rate_hz_m;
  logic [SAMPLE_W-1:0] prev_sample_m;
  logic                rising_m;
  int unsigned         seen_m;
  logic [GAP_W-1:0]    first_ext_m;
  logic [GAP_W-1:0]    second_ext_m;
  logic [1:0]          ext_count_m;

  estimate_t           estimates_q[$];
  logic [SAMPLE_W-1:0] pattern_q[$];
  int unsigned         mismatches;
  int unsigned         items_sent;
  bit                  steady_sender;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic clear_block_state();
    prev_sample_m = '0;
    rising_m      = 1'b0;
    seen_m        = 0;
    first_ext_m   = '0;
    second_ext_m  = '0;
    ext_count_m   = '0;
  endtask

  // advances the predicted state by one accepted sample
  task automatic predict_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
    int unsigned      pair;
    logic             dir;
    logic [GAP_W-1:0] gap;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    estimate_t        est;
    if (seen_m > 0 && seen_m < MAX_BLOCK_SAMPLES) begin
      pair = seen_m - 1;
      dir  = (prev_sample_m < value);
      if (ext_count_m < 2) begin
        if (pair > 0 && dir != rising_m) begin
          if (ext_count_m == 0) first_ext_m = GAP_W'(pair);
          else second_ext_m = GAP_W'(pair);
          ext_count_m = ext_count_m + 2'd1;
        end
        rising_m = dir;
      end
    end
    prev_sample_m = value;
    if (seen_m < MAX_BLOCK_SAMPLES) seen_m++;
    if (is_last) begin
      if (ext_count_m < 2) begin
        est.frequency_q8 = '0;
        est.half_period  = '0;
        est.no_estimate  = 1'b1;
      end else begin
        gap = second_ext_m - first_ext_m;
        num = {rate_hz_m, {FRAC_W{1'b0}}};
        den = {gap, 1'b0};
        est.frequency_q8 = (den != 0) ? FREQ_W'(num / den) : '0;
        est.half_period  = gap;
        est.no_estimate  = 1'b0;
      end
      estimates_q.push_back(est);
      clear_block_state();
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    estimate_t want;
    if (rst_ni && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (estimates_q.size() == 0) begin
        report_mismatch("result with no estimate pending", result_if.frequency_q8, 0);
      end else begin
        want = estimates_q.pop_front();
        if (result_if.frequency_q8 !== want.frequency_q8)
          report_mismatch("frequency_q8", result_if.frequency_q8, want.frequency_q8);
        if (result_if.half_period_samples !== want.half_period)
          report_mismatch("half_period_samples", result_if.half_period_samples,
                          want.half_period);
        if (result_if.no_estimate !== want.no_estimate)
          report_mismatch("no_estimate", result_if.no_estimate, want.no_estimate);
      end
    end
  end

  // result side: short stalls, rare long ones, and long stall-free stretches
  initial begin
    int unsigned r;
    result_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        result_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else if (r < 80) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else if (r < 92) begin
        result_if.ready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RATE_W'(1);
      2:       return '1;
      3:       return RATE_W'(1000000);
      default: return RATE_W'($urandom_range(1, 1000000));
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
    int unsigned idle;
    sample_if.valid        <= 1'b1;
    sample_if.sample_value <= value;
    sample_if.block_last   <= is_last;
    do @(posedge clk_i); while (sample_if.ready !== 1'b1);
    predict_sample(value, is_last);
    items_sent++;
    idle = steady_sender ? 0 : pick_gap();
    if (idle > 0) begin
      sample_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  task automatic send_pattern();
    foreach (pattern_q[i]) send_sample(pattern_q[i], i == pattern_q.size() - 1);
  endtask

  // stop sending and wait for every pending estimate
  task automatic drain_estimates();
    sample_if.valid <= 1'b0;
    while (estimates_q.size() != 0) @(posedge clk_i);
  endtask

  // block idle: no estimate pending and the divider surely finished
  task automatic wait_idle();
    drain_estimates();
    repeat (32) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] rate);
    cfg_if.valid          <= 1'b1;
    cfg_if.sample_rate_hz <= rate;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    rate_hz_m = rate;
    cfg_if.valid <= 1'b0;
  endtask

  // triangle waves with random slope and half period, some with spikes,
  // plus raw noise and flat blocks
  task automatic send_random_block(input int unsigned len);
    int unsigned mode;
    int          level;
    int          step;
    int unsigned half;
    int unsigned run;
    bit          up;
    logic [SAMPLE_W-1:0] value;
    mode  = $urandom_range(0, 9);
    level = $urandom_range(0, 65535);
    step  = $urandom_range(1, 2000);
    half  = $urandom_range(1, 24);
    run   = 0;
    up    = $urandom_range(0, 1);
    for (int unsigned i = 0; i < len; i++) begin
      if (mode < 2) begin
        value = SAMPLE_W'($urandom_range(0, 65535));
      end else if (mode == 2) begin
        value = SAMPLE_W'(level);
      end else begin
        if (run == half) begin
          up  = !up;
          run = 0;
        end
        level = up ? level + step : level - step;
        if (level < 0) level = 0;
        if (level > 65535) level = 65535;
        run++;
        value = SAMPLE_W'(level);
        if (mode > 7 && $urandom_range(0, 9) == 0) value = SAMPLE_W'($urandom_range(0, 65535));
      end
      send_sample(value, i == len - 1);
    end
  endtask

  task automatic test_short_blocks();
    // single sample, then a first change only at pair zero
    pattern_q = '{16'hFFFF};
    send_pattern();
    pattern_q = '{16'h0000, 16'hFFFF};
    send_pattern();
    // flat block has no extrema
    pattern_q = '{16'd7, 16'd7, 16'd7, 16'd7};
    send_pattern();
    // full swing alternation gives the smallest gap
    pattern_q = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
    send_pattern();
    // equal samples count as falling
    pattern_q = '{16'd1, 16'd2, 16'd2, 16'd3};
    send_pattern();
    // gap of three, then samples that must be ignored
    pattern_q = '{16'd9, 16'd5, 16'd9, 16'd12, 16'd15, 16'd3, 16'h0000, 16'hFFFF};
    send_pattern();
  endtask

  task automatic test_rate_settings();
    logic [RATE_W-1:0] rates [6];
    rates[0] = RATE_W'(1);
    rates[1] = '0;
    rates[2] = '1;
    rates[3] = RATE_W'(1000000);
    rates[4] = RATE_W'($urandom_range(2, 999999));
    rates[5] = RATE_RESET;
    foreach (rates[i]) begin
      wait_idle();
      write_rate(rates[i]);
      pattern_q = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
      send_pattern();
      send_random_block($urandom_range(10, 40));
    end
  endtask

  task automatic test_long_block();
    logic [SAMPLE_W-1:0] value;
    // widest gap: extrema at pair one and at the last pair looked at
    steady_sender = 1'b1;
    for (int unsigned i = 0; i < 1100; i++) begin
      if (i == 1) value = 16'd200;
      else if (i == 1023) value = 16'd500;
      else if (i > 1023) value = SAMPLE_W'($urandom_range(0, 65535));
      else value = 16'd100;
      send_sample(value, i == 1099);
    end
    steady_sender = 1'b0;
    // second change falls one pair past the limit
    for (int unsigned i = 0; i < 1025; i++) begin
      if (i == 1) value = 16'd200;
      else if (i == 1024) value = 16'd500;
      else value = 16'd100;
      send_sample(value, i == 1024);
    end
  endtask

  task automatic test_random_blocks();
    int unsigned start;
    int unsigned r;
    int unsigned len;
    start = items_sent;
    while (items_sent - start < 700) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        wait_idle();
        write_rate(pick_rate());
      end else if (r < 14) begin
        drain_estimates();
      end
      steady_sender = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 90) len = $urandom_range(1, 40);
      else if (r < 98) len = $urandom_range(41, 200);
      else len = $urandom_range(201, 300);
      send_random_block(len);
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    sample_if.valid        <= 1'b0;
    sample_if.sample_value <= '0;
    sample_if.block_last   <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.sample_rate_hz  <= '0;
    mismatches    = 0;
    items_sent    = 0;
    steady_sender = 1'b0;
    rate_hz_m     = RATE_RESET;
    clear_block_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_blocks();
    test_rate_settings();
    test_long_block();
    test_random_blocks();
    wait_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
